// ===== rtl/core/frame_packet_reassembler_defines.svh =====
// Assertion macros for the frame packet reassembler checkers.
// Used by the port checker; no other dependencies.
`ifndef FRAME_PACKET_REASSEMBLER_DEFINES_SVH
`define FRAME_PACKET_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpr port check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpr port check failed");

`endif

// ===== rtl/core/fpr_pkg.sv =====
// Shared constants and types of the frame packet reassembler.
// No dependencies; imported by every fpr module.
package fpr_pkg;

   localparam int MAX_PACKETS   = 1024;
   localparam int PAYLOAD_BYTES = 1024;

   localparam int SEQ_W   = $clog2(MAX_PACKETS);
   localparam int CNT_W   = $clog2(MAX_PACKETS + 1);
   localparam int OFF_W   = $clog2(PAYLOAD_BYTES + 1);
   localparam int ADDR_W  = 20;
   localparam int EPOCH_W = 8;

   localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
   localparam logic [SEQ_W-1:0]   MAP_LAST  = SEQ_W'(MAX_PACKETS - 1);

   typedef struct packed {
      logic [31:0] frame_id;
      logic [31:0] seq;
      logic [31:0] pkt_total;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic        packet_start;
      logic        has_payload;
      logic [7:0]  payload_byte;
   } item_type;

   typedef struct packed {
      logic              mem_write;
      logic [ADDR_W-1:0] mem_address;
      logic [7:0]        mem_data;
      logic              packet_accepted;
      logic              frame_closed;
      logic [31:0]       closed_frame_id;
      logic [31:0]       closed_width;
      logic [31:0]       closed_height;
      logic [CNT_W-1:0]  closed_received;
      logic [CNT_W-1:0]  closed_total;
      logic              frame_rejected;
   } result_type;

   // received-map write: entry tagged with the epoch of the open frame
   typedef struct packed {
      logic               en;
      logic [SEQ_W-1:0]   addr;
      logic [EPOCH_W-1:0] tag;
   } map_wr_type;

endpackage

// ===== rtl/core/frame_packet_reassembler.sv =====
// Frame packet reassembler: packets into frame-memory byte writes, frame reports.
// Depends on fpr_pkg, fpr_bitmap and fpr_tracker.
//
// Usage:
//   req_* carries one request per cycle: a packet's header fields plus at most
//   one payload byte; req_packet_start marks the first request of a packet.
//   rsp_* returns exactly one result per request, in order: a frame-memory
//   byte write, the packet-accepted flag, and a close report / reject flag.
// Pipeline: two registers, request stage then result stage; a request waits in
//   the request stage during a map sweep or while the result stage is stalled.
// Throughput: one request per cycle unless a sweep or a result stall intervenes;
//   the received map is read when a request is taken and written when it leaves
//   the request stage; a same-sequence hit of back-to-back requests is forwarded.
// Reset: clears all frame state, then sweeps the 1024-entry received map,
//   one entry per cycle; req_ready stays low until the sweep has ended.
//   Map entries carry an 8-bit frame tag; a frame opened once the tag has
//   reached 255 triggers the same sweep before that request is processed.
// Stall: when rsp_ready is low the result register holds; the request stage
//   still takes one more request, after which req_ready drops.
module frame_packet_reassembler
   import fpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_frame_id,
   input  logic [31:0]       req_seq,
   input  logic [31:0]       req_pkt_total,
   input  logic [31:0]       req_image_width,
   input  logic [31:0]       req_image_height,
   input  logic              req_packet_start,
   input  logic              req_has_payload,
   input  logic [7:0]        req_payload_byte,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_mem_write,
   output logic [ADDR_W-1:0] rsp_mem_address,
   output logic [7:0]        rsp_mem_data,
   output logic              rsp_packet_accepted,
   output logic              rsp_frame_closed,
   output logic [31:0]       rsp_closed_frame_id,
   output logic [31:0]       rsp_closed_width,
   output logic [31:0]       rsp_closed_height,
   output logic [CNT_W-1:0]  rsp_closed_received,
   output logic [CNT_W-1:0]  rsp_closed_total,
   output logic              rsp_frame_rejected
);

   // request stage
   item_type           s1_item_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               fwd_ff, fwd_in;

   // result stage
   result_type         rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_take, advance, clr_start, clr_busy, need_wrap;
   logic [EPOCH_W-1:0] rd_tag;
   result_type         step_result;
   map_wr_type         map_wr;

   // a frame open that would wrap the map tag waits for a sweep first
   assign clr_start = need_wrap && !clr_busy;
   assign advance   = s1_valid_ff && !clr_busy && !need_wrap && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy && (!s1_valid_ff || advance);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
      // map read lands before the write of the request ahead: forward it
      fwd_in = map_wr.en && (map_wr.addr == req_seq[SEQ_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.frame_id      <= req_frame_id;
         s1_item_ff.seq           <= req_seq;
         s1_item_ff.pkt_total     <= req_pkt_total;
         s1_item_ff.image_width   <= req_image_width;
         s1_item_ff.image_height  <= req_image_height;
         s1_item_ff.packet_start  <= req_packet_start;
         s1_item_ff.has_payload   <= req_has_payload;
         s1_item_ff.payload_byte  <= req_payload_byte;
         fwd_ff                   <= fwd_in;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   fpr_bitmap u_bitmap (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_take),
      .rd_addr   (req_seq[SEQ_W-1:0]),
      .rd_tag    (rd_tag),
      .map_wr    (map_wr),
      .clr_start (clr_start),
      .clr_busy  (clr_busy)
   );

   fpr_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .item       (s1_item_ff),
      .item_valid (s1_valid_ff),
      .step       (advance),
      .rd_tag     (rd_tag),
      .fwd_hit    (fwd_ff),
      .clr_start  (clr_start),
      .result     (step_result),
      .map_wr     (map_wr),
      .need_wrap  (need_wrap)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mem_write       = rsp_ff.mem_write;
   assign rsp_mem_address     = rsp_ff.mem_address;
   assign rsp_mem_data        = rsp_ff.mem_data;
   assign rsp_packet_accepted = rsp_ff.packet_accepted;
   assign rsp_frame_closed    = rsp_ff.frame_closed;
   assign rsp_closed_frame_id = rsp_ff.closed_frame_id;
   assign rsp_closed_width    = rsp_ff.closed_width;
   assign rsp_closed_height   = rsp_ff.closed_height;
   assign rsp_closed_received = rsp_ff.closed_received;
   assign rsp_closed_total    = rsp_ff.closed_total;
   assign rsp_frame_rejected  = rsp_ff.frame_rejected;

endmodule

// ===== rtl/core/fpr_bitmap.sv =====
// Received-packet map: one epoch tag per sequence number, plus clearing sweep.
// Depends on fpr_pkg.
module fpr_bitmap
   import fpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [SEQ_W-1:0]   rd_addr,
   output logic [EPOCH_W-1:0] rd_tag,
   input  map_wr_type         map_wr,
   input  logic               clr_start,
   output logic               clr_busy
);

   logic [EPOCH_W-1:0] tag_mem [MAX_PACKETS];
   logic [EPOCH_W-1:0] rd_tag_ff;
   logic               busy_ff, busy_in;
   logic [SEQ_W-1:0]   clr_addr_ff, clr_addr_in;

   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == MAP_LAST) begin
            busy_in = 1'b0;
         end
      end else if (clr_start) begin
         busy_in     = 1'b1;
         clr_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // tag 0 never matches an open frame
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         tag_mem[clr_addr_ff] <= '0;
      end else if (map_wr.en) begin
         tag_mem[map_wr.addr] <= map_wr.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff <= tag_mem[rd_addr];
      end
   end

   assign rd_tag   = rd_tag_ff;
   assign clr_busy = busy_ff;

endmodule

// ===== rtl/core/fpr_tracker.sv =====
// Frame state and per-request decision logic: open/close/reject, dedupe, byte write.
// Depends on fpr_pkg.
module fpr_tracker
   import fpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  item_type           item,
   input  logic               item_valid,
   input  logic               step,
   input  logic [EPOCH_W-1:0] rd_tag,
   input  logic               fwd_hit,
   input  logic               clr_start,
   output result_type         result,
   output map_wr_type         map_wr,
   output logic               need_wrap
);

   logic               active_ff, active_in;
   logic [31:0]        frame_id_ff, frame_id_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [31:0]        width_ff, width_in;
   logic [31:0]        height_ff, height_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               accepting_ff, accepting_in;
   logic [SEQ_W-1:0]   cur_seq_ff, cur_seq_in;
   logic [OFF_W-1:0]   offset_ff, offset_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;

   logic               opening, reject, seen, in_range, accept, byte_wr;
   logic [CNT_W-1:0]   eff_total;

   always_comb begin
      opening   = item.packet_start && (!active_ff || item.frame_id != frame_id_ff);
      reject    = opening && (item.pkt_total > 32'(MAX_PACKETS));
      eff_total = opening ? item.pkt_total[CNT_W-1:0] : total_ff;
      seen      = !opening && (fwd_hit || rd_tag == epoch_ff);
      in_range  = (item.seq < 32'(eff_total)) && (item.seq < 32'(MAX_PACKETS));
      accept    = item.packet_start && !reject && in_range && !seen;
      need_wrap = item_valid && opening && !reject && epoch_ff == EPOCH_MAX;

      active_in    = active_ff;
      frame_id_in  = frame_id_ff;
      total_in     = total_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      count_in     = count_ff;
      accepting_in = accepting_ff;
      cur_seq_in   = cur_seq_ff;
      offset_in    = offset_ff;
      epoch_in     = epoch_ff;
      result       = '0;

      if (item.packet_start) begin
         accepting_in = accept;
         offset_in    = '0;
         if (opening) begin
            if (active_ff) begin
               result.frame_closed    = 1'b1;
               result.closed_frame_id = frame_id_ff;
               result.closed_width    = width_ff;
               result.closed_height   = height_ff;
               result.closed_received = count_ff;
               result.closed_total    = total_ff;
            end
            count_in   = '0;
            cur_seq_in = '0;
            if (reject) begin
               result.frame_rejected = 1'b1;
               active_in   = 1'b0;
               frame_id_in = '0;
               total_in    = '0;
               width_in    = '0;
               height_in   = '0;
            end else begin
               active_in   = 1'b1;
               frame_id_in = item.frame_id;
               total_in    = eff_total;
               width_in    = item.image_width;
               height_in   = item.image_height;
               epoch_in    = epoch_ff + 1'b1;
            end
         end
         if (accept) begin
            count_in   = count_in + 1'b1;
            cur_seq_in = item.seq[SEQ_W-1:0];
            result.packet_accepted = 1'b1;
         end
      end

      byte_wr = item.has_payload && accepting_in && (offset_in < OFF_W'(PAYLOAD_BYTES));
      if (byte_wr) begin
         result.mem_write   = 1'b1;
         result.mem_address = ADDR_W'(32'(cur_seq_in) * PAYLOAD_BYTES + 32'(offset_in));
         result.mem_data    = item.payload_byte;
         offset_in          = offset_in + 1'b1;
      end

      map_wr.en   = step && accept;
      map_wr.addr = item.seq[SEQ_W-1:0];
      map_wr.tag  = epoch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         frame_id_ff  <= '0;
         total_ff     <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         count_ff     <= '0;
         accepting_ff <= 1'b0;
         cur_seq_ff   <= '0;
         offset_ff    <= '0;
         epoch_ff     <= '0;
      end else if (clr_start) begin
         epoch_ff <= '0;
      end else if (step) begin
         active_ff    <= active_in;
         frame_id_ff  <= frame_id_in;
         total_ff     <= total_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         count_ff     <= count_in;
         accepting_ff <= accepting_in;
         cur_seq_ff   <= cur_seq_in;
         offset_ff    <= offset_in;
         epoch_ff     <= epoch_in;
      end
   end

endmodule

// ===== rtl/core/fpr_port_checker.sv =====
// Port-level checks of the frame packet reassembler, bound to the top level.
// Depends on fpr_pkg and frame_packet_reassembler_defines.svh.
`include "frame_packet_reassembler_defines.svh"

module fpr_port_checker
   import fpr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_mem_write,
   input logic [ADDR_W-1:0] rsp_mem_address,
   input logic [7:0]        rsp_mem_data,
   input logic              rsp_packet_accepted,
   input logic              rsp_frame_closed,
   input logic [CNT_W-1:0]  rsp_closed_received,
   input logic [CNT_W-1:0]  rsp_closed_total,
   input logic              rsp_frame_rejected
);

   // map sweep after reset holds off requests
   `FPR_ASSERT_NOW(a_sweep_after_reset, clock, 1'b0, $past(reset), !req_ready)

   // a rejected frame takes no packet and writes no byte
   `FPR_ASSERT_NOW(a_reject_quiet, clock, reset, rsp_valid && rsp_frame_rejected,
      !rsp_mem_write && !rsp_packet_accepted)

   // distinct in-range sequence numbers only
   `FPR_ASSERT_NOW(a_close_count, clock, reset, rsp_valid && rsp_frame_closed,
      rsp_closed_received <= rsp_closed_total)

   // stalled result holds
   `FPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_mem_write) && $stable(rsp_mem_address) && $stable(rsp_mem_data))

endmodule

bind frame_packet_reassembler fpr_port_checker u_port_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for frame_packet_reassembler: directed table, then random frames.
// Depends on fpr_pkg and the frame_packet_reassembler RTL; nothing else.
module testbench;
   import fpr_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int ITEM_TARGET   = 1750;
   localparam int MIN_FRAMES    = 300;   // past the 255-frame tag wrap of the received map
   localparam int OVERRUN_BYTES = 1030;  // one packet longer than PAYLOAD_BYTES
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int HOLD_AFTER    = 300;   // results seen before the hold-off starts
   localparam int DRAIN_CYCLES  = 16;
   localparam int REPORT_MAX    = 10;
   // Longest correct quiet stretch: a map sweep plus the hold-off plus
   // short gaps and stalls; taken several times over.
   localparam int IDLE_LIMIT    = 6000;

   // one row of the directed table; want is used only where typed is set
   typedef struct packed {
      item_type   it;
      logic       typed;
      result_type want;
   } step_type;

   logic              clock = 1'b0;
   logic              reset;

   logic              req_valid;
   logic              req_ready;
   logic [31:0]       req_frame_id;
   logic [31:0]       req_seq;
   logic [31:0]       req_pkt_total;
   logic [31:0]       req_image_width;
   logic [31:0]       req_image_height;
   logic              req_packet_start;
   logic              req_has_payload;
   logic [7:0]        req_payload_byte;

   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_mem_write;
   logic [ADDR_W-1:0] rsp_mem_address;
   logic [7:0]        rsp_mem_data;
   logic              rsp_packet_accepted;
   logic              rsp_frame_closed;
   logic [31:0]       rsp_closed_frame_id;
   logic [31:0]       rsp_closed_width;
   logic [31:0]       rsp_closed_height;
   logic [CNT_W-1:0]  rsp_closed_received;
   logic [CNT_W-1:0]  rsp_closed_total;
   logic              rsp_frame_rejected;

   // Mirror of the reassembly state, kept in step with every accepted request.
   logic              frm_active;
   logic [31:0]       frm_id;
   logic [31:0]       frm_total;
   logic [31:0]       frm_width;
   logic [31:0]       frm_height;
   logic [CNT_W-1:0]  frm_received;
   bit                frm_map [MAX_PACKETS];
   logic              frm_taking;
   logic [SEQ_W-1:0]  frm_seq;
   int                frm_offset;

   result_type        awaited_rsp [$];   // one result owed per accepted request
   step_type          plan [$];

   int                burst_left    = 0;
   int                items_sent    = 0;
   int                frames_opened = 0;
   int                rsp_count     = 0;
   int                mismatch_count = 0;
   int                idle_cycles   = 0;
   logic [31:0]       last_frame_id = '0;

   frame_packet_reassembler u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_id        (req_frame_id),
      .req_seq             (req_seq),
      .req_pkt_total       (req_pkt_total),
      .req_image_width     (req_image_width),
      .req_image_height    (req_image_height),
      .req_packet_start    (req_packet_start),
      .req_has_payload     (req_has_payload),
      .req_payload_byte    (req_payload_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mem_write       (rsp_mem_write),
      .rsp_mem_address     (rsp_mem_address),
      .rsp_mem_data        (rsp_mem_data),
      .rsp_packet_accepted (rsp_packet_accepted),
      .rsp_frame_closed    (rsp_frame_closed),
      .rsp_closed_frame_id (rsp_closed_frame_id),
      .rsp_closed_width    (rsp_closed_width),
      .rsp_closed_height   (rsp_closed_height),
      .rsp_closed_received (rsp_closed_received),
      .rsp_closed_total    (rsp_closed_total),
      .rsp_frame_rejected  (rsp_frame_rejected)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void clear_frame();
      frm_active   = 1'b0;
      frm_id       = '0;
      frm_total    = '0;
      frm_width    = '0;
      frm_height   = '0;
      frm_received = '0;
      foreach (frm_map[i]) frm_map[i] = 1'b0;
      frm_taking   = 1'b0;
      frm_seq      = '0;
      frm_offset   = 0;
   endfunction

   // Result owed for one request; updates the mirrored frame state.
   function automatic result_type reassemble(input item_type it);
      result_type r;
      r = '0;
      if (it.packet_start) begin
         // every start item ends the previous packet's byte stream
         frm_taking = 1'b0;
         frm_offset = 0;
         if (!frm_active || it.frame_id != frm_id) begin
            if (frm_active) begin
               r.frame_closed    = 1'b1;
               r.closed_frame_id = frm_id;
               r.closed_width    = frm_width;
               r.closed_height   = frm_height;
               r.closed_received = frm_received;
               r.closed_total    = frm_total[CNT_W-1:0];
            end
            clear_frame();
            // oversized frame: stay inactive, no byte is taken
            if (it.pkt_total > 32'(MAX_PACKETS)) begin
               r.frame_rejected = 1'b1;
               return r;
            end
            frm_active   = 1'b1;
            frm_id       = it.frame_id;
            frm_total    = it.pkt_total;
            frm_width    = it.image_width;
            frm_height   = it.image_height;
         end
         // in range and not yet seen: accept; otherwise the packet is dropped
         if (it.seq < frm_total && it.seq < 32'(MAX_PACKETS)
             && !frm_map[it.seq[SEQ_W-1:0]]) begin
            frm_map[it.seq[SEQ_W-1:0]] = 1'b1;
            frm_received = frm_received + 1'b1;
            frm_taking   = 1'b1;
            frm_seq      = it.seq[SEQ_W-1:0];
            r.packet_accepted = 1'b1;
         end
      end
      // bytes past the payload size are dropped
      if (it.has_payload && frm_taking && frm_offset < PAYLOAD_BYTES) begin
         r.mem_write   = 1'b1;
         r.mem_address = ADDR_W'(int'(frm_seq) * PAYLOAD_BYTES + frm_offset);
         r.mem_data    = it.payload_byte;
         frm_offset++;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic item_type make_item(input logic [31:0] id, input logic [31:0] seq,
                                          input logic [31:0] total, input logic [31:0] w,
                                          input logic [31:0] h, input logic start,
                                          input logic has, input logic [7:0] data);
      item_type it;
      it.frame_id      = id;
      it.seq           = seq;
      it.pkt_total     = total;
      it.image_width   = w;
      it.image_height  = h;
      it.packet_start  = start;
      it.has_payload   = has;
      it.payload_byte  = data;
      return it;
   endfunction

   function automatic result_type make_result(input logic wr, input logic [ADDR_W-1:0] addr,
                                              input logic [7:0] data, input logic acc,
                                              input logic closed, input logic [31:0] cid,
                                              input logic [31:0] cw, input logic [31:0] ch,
                                              input logic [CNT_W-1:0] crec,
                                              input logic [CNT_W-1:0] ctot,
                                              input logic rej);
      return {wr, addr, data, acc, closed, cid, cw, ch, crec, ctot, rej};
   endfunction

   function automatic void add_step(input item_type it, input logic typed,
                                    input result_type want);
      step_type s;
      s.it    = it;
      s.typed = typed;
      s.want  = want;
      plan.push_back(s);
   endfunction

   // non-start request: header fields are random and must be ignored
   function automatic item_type body_item(input bit has);
      return make_item($urandom, $urandom, $urandom, $urandom, $urandom, 1'b0, has,
                       8'($urandom_range(0, 255)));
   endfunction

   // Offer one request; the sender runs in bursts with idle gaps between them.
   // The owed result is queued at the edge that accepts the request.
   task automatic offer(input item_type it, input logic typed, input result_type want);
      int gap;
      result_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_frame_id      <= it.frame_id;
      req_seq           <= it.seq;
      req_pkt_total     <= it.pkt_total;
      req_image_width   <= it.image_width;
      req_image_height  <= it.image_height;
      req_packet_start  <= it.packet_start;
      req_has_payload   <= it.has_payload;
      req_payload_byte  <= it.payload_byte;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = reassemble(it);
      awaited_rsp.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Single-request frame under a fresh id: runs the map's frame tag through
   // its wrap without spending many requests.
   task automatic quick_frame();
      logic [31:0] id, total;
      id    = last_frame_id + 1;
      total = $urandom_range(1, 8);
      last_frame_id = id;
      frames_opened++;
      offer(make_item(id, $urandom_range(0, 9), total, $urandom, $urandom, 1'b1,
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))), 1'b0, '0);
   endtask

   // One frame: a header, a few packets (mostly in range, some duplicate or out
   // of range) and a few payload bytes each. Some frames are oversized or empty.
   task automatic random_frame();
      logic [31:0] id, total, w, h, seq, last_seq;
      int pick, n_pkts, n_bytes;
      bit reuse;
      reuse = ($urandom_range(0, 9) == 0);
      id    = reuse ? last_frame_id : $urandom;
      pick  = $urandom_range(0, 99);
      if (pick < 5)       total = '0;
      else if (pick < 9)  total = MAX_PACKETS + $urandom_range(1, 3);
      else if (pick < 12) total = $urandom | 32'h8000_0000;
      else if (pick < 18) total = MAX_PACKETS;
      else                total = $urandom_range(1, 8);
      if (!reuse && total <= 32'(MAX_PACKETS)) frames_opened++;
      last_frame_id = id;
      w        = $urandom;
      h        = $urandom;
      last_seq = '0;
      n_pkts   = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0)
         offer(body_item(1'($urandom_range(0, 1))), 1'b0, '0);
      repeat (n_pkts) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            if (total == 0)                       seq = $urandom_range(0, 3);
            else if (total > 32'(MAX_PACKETS))    seq = $urandom_range(0, 7);
            else                                  seq = $urandom_range(0, total - 1);
         end else if (pick < 9) begin
            seq = last_seq;   // duplicate
         end else begin
            seq = $urandom_range(0, 1) ? total + $urandom_range(0, 2) : $urandom;
         end
         last_seq = seq;
         offer(make_item(id, seq, total, w, h, 1'b1, $urandom_range(0, 4) != 0,
                         8'($urandom_range(0, 255))), 1'b0, '0);
         n_bytes = $urandom_range(0, 3);
         repeat (n_bytes) offer(body_item($urandom_range(0, 5) != 0), 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] id;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_frame_id      <= '0;
      req_seq           <= '0;
      req_pkt_total     <= '0;
      req_image_width   <= '0;
      req_image_height  <= '0;
      req_packet_start  <= 1'b0;
      req_has_payload   <= 1'b0;
      req_payload_byte  <= '0;
      clear_frame();

      // Directed table. Typed rows: results readable straight off the rules.
      // stray byte right after reset
      add_step(make_item(0, 0, 0, 0, 0, 1'b0, 1'b1, 8'hFF), 1'b1, '0);
      // first frame, largest total, widest width; seq 0 taken
      add_step(make_item(0, 0, MAX_PACKETS, 32'hFFFF_FFFF, 0, 1'b1, 1'b1, 8'hA5), 1'b1,
               make_result(1'b1, 20'h0, 8'hA5, 1'b1, 1'b0, 0, 0, 0, 0, 0, 1'b0));
      // continuation byte; all-ones header on a non-start request is ignored
      add_step(make_item('1, '1, '1, '1, '1, 1'b0, 1'b1, 8'h5A), 1'b1,
               make_result(1'b1, 20'h1, 8'h5A, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0));
      // header-only continuation writes nothing
      add_step(make_item(0, 0, 0, 0, 0, 1'b0, 1'b0, 8'hFF), 1'b1, '0);
      // highest seq: top of the address range
      add_step(make_item(0, MAX_PACKETS - 1, MAX_PACKETS, 0, 0, 1'b1, 1'b1, 8'h00), 1'b1,
               make_result(1'b1, 20'hFFC00, 8'h00, 1'b1, 1'b0, 0, 0, 0, 0, 0, 1'b0));
      // duplicate packet is dropped, its bytes too
      add_step(make_item(0, MAX_PACKETS - 1, MAX_PACKETS, 0, 0, 1'b1, 1'b1, 8'h3C), 1'b1, '0);
      add_step(make_item(0, 0, 0, 0, 0, 1'b0, 1'b1, 8'hC3), 1'b1, '0);
      // seq out of range: at the total, and all ones
      add_step(make_item(0, MAX_PACKETS, MAX_PACKETS, 0, 0, 1'b1, 1'b1, 8'h11), 1'b1, '0);
      add_step(make_item(0, '1, MAX_PACKETS, 0, 0, 1'b1, 1'b0, 8'h00), 1'b1, '0);
      // new id closes the frame; zero total leaves every seq out of range
      add_step(make_item('1, 0, 0, 32'h1234_5678, 32'h0000_FFFF, 1'b1, 1'b1, 8'h22), 1'b1,
               make_result(1'b0, 0, 0, 1'b0, 1'b1, 0, 32'hFFFF_FFFF, 0, 2,
                           CNT_W'(MAX_PACKETS), 1'b0));
      add_step(make_item('1, 0, 0, 0, 0, 1'b1, 1'b1, 8'h33), 1'b1, '0);
      // oversized frame: close report plus reject
      add_step(make_item(7, 0, MAX_PACKETS + 1, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1,
                         8'h44), 1'b1,
               make_result(1'b0, 0, 0, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678,
                           32'h0000_FFFF, 0, 0, 1'b1));
      // inactive: stray byte, then a reject with nothing to close
      add_step(make_item(7, 0, 0, 0, 0, 1'b0, 1'b1, 8'h55), 1'b1, '0);
      add_step(make_item(7, 0, '1, 0, 0, 1'b1, 1'b1, 8'h66), 1'b1,
               make_result(1'b0, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b1));
      // id 0 still opens a frame while inactive; header-only start
      add_step(make_item(0, 0, 1, 0, 0, 1'b1, 1'b0, 8'h77), 1'b1,
               make_result(1'b0, 0, 0, 1'b1, 1'b0, 0, 0, 0, 0, 0, 1'b0));
      // the rest goes through the predictor
      add_step(make_item(0, 0, 0, 0, 0, 1'b0, 1'b1, 8'h88), 1'b0, '0);
      add_step(make_item(0, 0, 1, 0, 0, 1'b1, 1'b1, 8'h99), 1'b0, '0);
      add_step(make_item(1, 1, 2, 32'hCAFE_0001, 32'h0BAD_0002, 1'b1, 1'b1, 8'hF0), 1'b0, '0);
      add_step(make_item(1, 0, 2, 0, 0, 1'b1, 1'b0, 8'h00), 1'b0, '0);
      add_step(make_item(1, 0, 0, 0, 0, 1'b0, 1'b0, 8'h01), 1'b0, '0);
      add_step(make_item(1, 0, 0, 0, 0, 1'b0, 1'b1, 8'h0F), 1'b0, '0);
      add_step(make_item(1, 2, 2, 0, 0, 1'b1, 1'b1, 8'hE1), 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) offer(plan[i].it, plan[i].typed, plan[i].want);

      // payload overrun: one packet with more bytes than a packet slot holds
      id = $urandom;
      offer(make_item(id, 2, 4, $urandom, $urandom, 1'b1, 1'b1, 8'($urandom_range(0, 255))),
            1'b0, '0);
      repeat (OVERRUN_BYTES) offer(body_item(1'b1), 1'b0, '0);

      // many short frames first, then mixed random frames up to the budget
      while (frames_opened < MIN_FRAMES) quick_frame();
      while (items_sent < ITEM_TARGET) random_frame();

      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random ready patterns, plus one long hold-off so the block
   // fills and pushes back on the request side.
   // ---------------------------------------------------------------------
   initial begin : receiver
      int mode, span, k;
      bit held;
      held = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held && rsp_count >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         for (k = 0; k < span; k++) begin
            case (mode)
               0: rsp_ready <= 1'b1;                          // no stalls
               1: rsp_ready <= 1'($urandom_range(0, 1));      // coin flip
               2: rsp_ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
               default: rsp_ready <= (k % 3 != 2);            // fixed pattern
            endcase
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   function automatic string diff_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want === got) return "";
      return $sformatf(" %s exp %0h got %0h", name, want, got);
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("%0t ERROR %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin : rsp_checker
      result_type got, want;
      string diffs;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_mem_write, rsp_mem_address, rsp_mem_data, rsp_packet_accepted,
                rsp_frame_closed, rsp_closed_frame_id, rsp_closed_width, rsp_closed_height,
                rsp_closed_received, rsp_closed_total, rsp_frame_rejected};
         rsp_count++;
         if (awaited_rsp.size() == 0) begin
            note_mismatch($sformatf("result %0d with no request owed: %h", rsp_count, got));
         end else begin
            want  = awaited_rsp.pop_front();
            diffs = {diff_field("mem_write", 32'(want.mem_write), 32'(got.mem_write)),
                     diff_field("mem_address", 32'(want.mem_address),
                                32'(got.mem_address)),
                     diff_field("mem_data", 32'(want.mem_data), 32'(got.mem_data)),
                     diff_field("packet_accepted", 32'(want.packet_accepted),
                                32'(got.packet_accepted)),
                     diff_field("frame_closed", 32'(want.frame_closed),
                                32'(got.frame_closed)),
                     diff_field("closed_frame_id", want.closed_frame_id,
                                got.closed_frame_id),
                     diff_field("closed_width", want.closed_width, got.closed_width),
                     diff_field("closed_height", want.closed_height, got.closed_height),
                     diff_field("closed_received", 32'(want.closed_received),
                                32'(got.closed_received)),
                     diff_field("closed_total", 32'(want.closed_total),
                                32'(got.closed_total)),
                     diff_field("frame_rejected", 32'(want.frame_rejected),
                                32'(got.frame_rejected))};
            if (diffs != "")
               note_mismatch($sformatf("result %0d:%s", rsp_count, diffs));
         end
      end
   end

   // Watchdog: too long without a request or a result moving means a hang.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
